>>> hw/rtl/rarst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarst_pkg
// Shared types and constants of the range-add / range-sum tree core.
// ----------------------------------------------------------------------------
package rarst_pkg;

	localparam int IDX_W  = 10;
	localparam int SIZE_W = 11;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 64;

	// Command kinds. The fourth code has no meaning and is rejected.
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_ADD   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [1:0]              kind;
		logic [IDX_W-1:0]        range_low;
		logic [IDX_W-1:0]        range_high;
		logic signed [VAL_W-1:0] operand_value;
	} cmd_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] range_sum;
		logic                    status;
	} res_t;

endpackage

>>> hw/rtl/rarst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarst_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rarst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1025,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             re,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> hw/rtl/range_add_range_sum_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_core
// Range add and range sum over a signed array, kept as a pair of binary
// indexed trees in two synchronous memories.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                    Handshake
//  --------  -------------------------  ---------------------------------
//  command   start, busy, cmd           taken when start is high, busy low
//  result    result_valid, result       one-cycle strobe, cannot stall
//  config    cfg_valid, cfg_ready,      written when valid and ready
//            cfg_data
//
// Every word gets exactly one result. A rejected word is answered in the cycle
// after it is taken and leaves busy low. Otherwise each tree node takes a
// memory read, then an accumulate or a write back. A range sum runs two
// prefix walks and then forms the result. A range add runs two update walks.
// A load runs both. After reset and after every size write the memories are
// cleared, one entry per cycle, with busy high. A size write offered while
// idle takes priority, so busy is high while cfg_valid is high and no word
// is taken in that cycle.
// The result side cannot stall, so results leave the output register at once.
//
// Method: the array is held as two trees B1 and B2. Adding v over [l, h]
// adds (v, v*l) at position l+1 and (-v, -v*(h+1)) at position h+2. The sum
// of the first p elements is p * B1(p) - B2(p). A load reads the element
// through two prefix sums and adds the new value minus it as a range add.
// All arithmetic wraps at 64 bits.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_core
	import rarst_pkg::*;
#(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cmd_t              cmd,
	output logic              result_valid,
	output res_t              result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

	localparam int DEPTH      = MAX_ELEMENTS + 1;
	localparam int AW         = $clog2(DEPTH);
	localparam int SW         = $clog2(MAX_ELEMENTS + 1);
	localparam int PW         = $clog2(MAX_ELEMENTS + 2) + 1;
	localparam int RESET_SIZE = (1024 > MAX_ELEMENTS) ? MAX_ELEMENTS : 1024;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_Q_RD, ST_Q_ACC, ST_Q_FIN, ST_CALC,
		ST_U_MUL, ST_U_RD, ST_U_WR
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [SW-1:0]       size_q;
	logic [1:0]          kind_q;
	logic [PW-1:0]       lo_q;
	logic [PW-1:0]       hi_q;
	logic [PW-1:0]       p_q;
	logic [SUM_W-1:0]    v_q;
	logic [SUM_W-1:0]    d_q;
	logic [SUM_W-1:0]    mterm_q;
	logic [SUM_W-1:0]    s1_q;
	logic [SUM_W-1:0]    s2_q;
	logic [SUM_W-1:0]    pre0_q;
	logic [SUM_W-1:0]    pre1_q;
	logic                qi_q;
	logic                ui_q;
	res_t                res_q;
	logic                res_valid_q;

	logic                ram_re;
	logic                ram_we;
	logic [AW-1:0]       ram_addr;
	logic [SUM_W-1:0]    wdata1;
	logic [SUM_W-1:0]    wdata2;
	logic [SUM_W-1:0]    rdata1;
	logic [SUM_W-1:0]    rdata2;

	logic [31:0]         lo32;
	logic [31:0]         hi32;
	logic [31:0]         sz32;
	logic [31:0]         cfg32;
	logic [31:0]         cfg_sz;
	logic                cmd_bad;
	logic [PW-1:0]       size_pw;
	logic [PW-1:0]       lowbit;
	logic [PW-1:0]       qpos;
	logic [SUM_W-1:0]    prefix;
	logic [SUM_W-1:0]    cur;
	logic [PW-1:0]       ukey;
	logic [SUM_W-1:0]    delta1;
	logic [SUM_W-1:0]    delta2;

	// A size write in the idle state wins over a word, so busy covers it.
	assign busy         = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready    = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Command checks are done on 32-bit copies so that any tree size fits.
	assign lo32  = 32'(cmd.range_low);
	assign hi32  = 32'(cmd.range_high);
	assign sz32  = 32'(size_q);
	assign cfg32 = 32'(cfg_data);

	always_comb begin
		unique case (cmd.kind)
			KIND_LOAD:  cmd_bad = (lo32 >= sz32);
			KIND_ADD,
			KIND_QUERY: cmd_bad = (hi32 >= sz32) || (lo32 > hi32);
			default:    cmd_bad = 1'b1;
		endcase
	end

	// A size of zero means one element; sizes above the maximum saturate.
	always_comb begin
		if (cfg32 == 32'd0) begin
			cfg_sz = 32'd1;
		end else if (cfg32 > 32'(MAX_ELEMENTS)) begin
			cfg_sz = 32'(MAX_ELEMENTS);
		end else begin
			cfg_sz = cfg32;
		end
	end

	assign size_pw = {{(PW-SW){1'b0}}, size_q};
	assign lowbit  = p_q & (~p_q + PW'(1));
	assign qpos    = qi_q ? lo_q : (hi_q + PW'(1));
	assign prefix  = (s1_q * {{(SUM_W-PW){1'b0}}, qpos}) - s2_q;
	assign cur     = pre0_q - pre1_q;
	assign ukey    = ui_q ? (hi_q + PW'(1)) : lo_q;
	assign delta1  = ui_q ? (~d_q + SUM_W'(1)) : d_q;
	assign delta2  = ui_q ? (~mterm_q + SUM_W'(1)) : mterm_q;

	assign ram_re   = (state_q == ST_Q_RD || state_q == ST_U_RD) && (p_q != '0)
		&& (p_q <= size_pw);
	assign ram_we   = (state_q == ST_CLEAR) || (state_q == ST_U_WR);
	assign ram_addr = (state_q == ST_CLEAR) ? clr_q : p_q[AW-1:0];
	assign wdata1   = (state_q == ST_CLEAR) ? '0 : (rdata1 + delta1);
	assign wdata2   = (state_q == ST_CLEAR) ? '0 : (rdata2 + delta2);

	rarst_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_b1 (
		.clk(clk), .re(ram_re), .we(ram_we), .addr(ram_addr),
		.wdata(wdata1), .rdata(rdata1)
	);

	rarst_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_b2 (
		.clk(clk), .re(ram_re), .we(ram_we), .addr(ram_addr),
		.wdata(wdata2), .rdata(rdata2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			size_q      <= SW'(RESET_SIZE);
			kind_q      <= KIND_LOAD;
			lo_q        <= '0;
			hi_q        <= '0;
			p_q         <= '0;
			v_q         <= '0;
			d_q         <= '0;
			mterm_q     <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
			pre0_q      <= '0;
			pre1_q      <= '0;
			qi_q        <= 1'b0;
			ui_q        <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cfg_valid) begin
						size_q  <= SW'(cfg_sz);
						clr_q   <= '0;
						state_q <= ST_CLEAR;
					end else if (start) begin
						kind_q <= cmd.kind;
						lo_q   <= PW'(cmd.range_low);
						// A load works on the one-element range at its index.
						hi_q   <= (cmd.kind == KIND_LOAD) ? PW'(cmd.range_low)
							: PW'(cmd.range_high);
						v_q    <= {{(SUM_W-VAL_W){cmd.operand_value[VAL_W-1]}},
							cmd.operand_value};
						d_q    <= {{(SUM_W-VAL_W){cmd.operand_value[VAL_W-1]}},
							cmd.operand_value};
						s1_q   <= '0;
						s2_q   <= '0;
						qi_q   <= 1'b0;
						ui_q   <= 1'b0;
						if (cmd_bad) begin
							res_q       <= '{range_sum: '0, status: STATUS_BAD};
							res_valid_q <= 1'b1;
						end else if (cmd.kind == KIND_ADD) begin
							state_q <= ST_U_MUL;
						end else begin
							p_q     <= (cmd.kind == KIND_LOAD)
								? PW'(cmd.range_low) + PW'(1)
								: PW'(cmd.range_high) + PW'(1);
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_Q_RD: begin
					state_q <= (p_q == '0) ? ST_Q_FIN : ST_Q_ACC;
				end
				ST_Q_ACC: begin
					s1_q    <= s1_q + rdata1;
					s2_q    <= s2_q + rdata2;
					p_q     <= p_q - lowbit;
					state_q <= ST_Q_RD;
				end
				ST_Q_FIN: begin
					if (!qi_q) begin
						pre0_q  <= prefix;
						qi_q    <= 1'b1;
						p_q     <= lo_q;
						s1_q    <= '0;
						s2_q    <= '0;
						state_q <= ST_Q_RD;
					end else begin
						pre1_q  <= prefix;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (kind_q == KIND_QUERY) begin
						res_q       <= '{range_sum: cur, status: STATUS_OK};
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						d_q     <= v_q - cur;
						state_q <= ST_U_MUL;
					end
				end
				ST_U_MUL: begin
					mterm_q <= d_q * {{(SUM_W-PW){1'b0}}, ukey};
					p_q     <= ukey + PW'(1);
					state_q <= ST_U_RD;
				end
				ST_U_RD: begin
					if (p_q > size_pw) begin
						if (!ui_q) begin
							ui_q    <= 1'b1;
							state_q <= ST_U_MUL;
						end else begin
							res_q       <= '{range_sum: '0, status: STATUS_OK};
							res_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end else begin
						state_q <= ST_U_WR;
					end
				end
				ST_U_WR: begin
					p_q     <= p_q + lowbit;
					state_q <= ST_U_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The two memories are never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_re && ram_we))
		else $error("memory read and write in the same cycle");

	// Write-back happens only inside the tree positions in use.
	a_wr_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_U_WR) |-> (p_q != '0 && p_q <= size_pw))
		else $error("tree write outside positions in use");

	// Accumulation and write-back always follow a read issued in the cycle before.
	a_acc_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_Q_ACC || state_q == ST_U_WR) |-> $past(ram_re))
		else $error("memory data used without a read");

	// A rejected word carries a zero sum.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == STATUS_BAD) |-> (result.range_sum == '0))
		else $error("rejected word with nonzero sum");

	// A size write always starts a clearing pass.
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (state_q == ST_CLEAR && clr_q == '0))
		else $error("size write without clearing pass");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the range-add / range-sum tree core: loads, range
// adds and range sums, plus rejected words, under several array sizes, each
// result checked against a flat array model with 64-bit wrapping sums.
// ----------------------------------------------------------------------------
module tb;
	import rarst_pkg::*;

	localparam int MAX_ELEMS  = 1024;
	localparam int CYCLE_CAP  = 2000000;
	localparam int DRAIN_WAIT = 80;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	cmd_t              cmd;
	logic              result_valid;
	res_t              result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data;

	range_add_range_sum_tree_core #(.MAX_ELEMENTS(MAX_ELEMS)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// The model keeps the plain element values. Since every tree operation
	// is linear in 64-bit wrapping arithmetic, a flat array gives the same
	// sums as the pair of binary indexed trees does.
	logic [SUM_W-1:0] elem_vals [MAX_ELEMS];
	int unsigned      array_size;
	res_t             pending_results [$];
	int               mismatch_count;
	int               word_count;
	int               query_count;
	int               reject_count;
	int               burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the core hangs.
	initial begin
		repeat (CYCLE_CAP) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void clear_elems();
		foreach (elem_vals[i]) elem_vals[i] = '0;
	endfunction

	// Works out the result of one accepted word and updates the array.
	function automatic res_t tree_outcome(cmd_t c);
		res_t             r;
		logic [SUM_W-1:0] ext;
		ext = {{(SUM_W-VAL_W){c.operand_value[VAL_W-1]}}, c.operand_value};
		r.range_sum = '0;
		r.status = STATUS_OK;
		if (c.kind == KIND_LOAD) begin
			if (c.range_low >= array_size) r.status = STATUS_BAD;
			else elem_vals[c.range_low] = ext;
		end else if (c.kind == KIND_ADD || c.kind == KIND_QUERY) begin
			if (c.range_high >= array_size || c.range_low > c.range_high) begin
				r.status = STATUS_BAD;
			end else begin
				for (int i = c.range_low; i <= c.range_high; i++) begin
					if (c.kind == KIND_ADD) elem_vals[i] = elem_vals[i] + ext;
					else r.range_sum = r.range_sum + elem_vals[i];
				end
			end
		end else begin
			// The fourth kind code has no meaning and is always rejected.
			r.status = STATUS_BAD;
		end
		return r;
	endfunction

	// Result checker: every strobe must match the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result: sum %0d status %0d",
						result.range_sum, result.status);
			end else begin
				if (result !== pending_results[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Mismatch: expected sum %0d status %0d, got sum %0d status %0d",
							pending_results[0].range_sum, pending_results[0].status,
							result.range_sum, result.status);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// Sends one word. The sender works in bursts; between bursts start drops
	// for a random number of cycles. Start is only raised here, so within a
	// burst it simply stays high.
	task automatic send_word(cmd_t c);
		res_t r;
		if (burst_left == 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
		end else begin
			@(negedge clk);
		end
		burst_left--;
		start <= 1'b1;
		cmd   <= c;
		// Busy only moves at rising edges while cfg_valid is low, so its value at
		// the falling edge decides whether the next rising edge takes the word.
		while (busy) @(negedge clk);
		@(posedge clk);
		r = tree_outcome(c);
		pending_results.push_back(r);
		word_count++;
		if (c.kind == KIND_QUERY) query_count++;
		if (r.status == STATUS_BAD) reject_count++;
	endtask

	// Drops start before the next edge so the last word is not taken twice,
	// waits until every result is back, then lets the core settle.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Writes the size register while the core is idle. The core then clears
	// its memories, which the next word simply waits out through busy.
	task automatic write_size(logic [SIZE_W-1:0] sz);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= sz;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		array_size = (sz == 0) ? 1 : (sz > MAX_ELEMS) ? MAX_ELEMS : sz;
		clear_elems();
	endtask

	function automatic cmd_t make_cmd(logic [1:0] k, int lo, int hi, logic [31:0] v);
		cmd_t c;
		c.kind = k;
		c.range_low = lo[IDX_W-1:0];
		c.range_high = hi[IDX_W-1:0];
		c.operand_value = v;
		return c;
	endfunction

	// Directed words: extreme indices and values, every kind, and each
	// rejection rule.
	task automatic test_directed();
		send_word(make_cmd(KIND_QUERY, 0, 1023, 32'd0));
		send_word(make_cmd(KIND_LOAD, 0, 0, 32'h7FFF_FFFF));
		send_word(make_cmd(KIND_LOAD, 1023, 0, 32'h8000_0000));
		send_word(make_cmd(KIND_LOAD, 511, 1023, 32'hFFFF_FFFF));
		send_word(make_cmd(KIND_QUERY, 0, 1023, 32'h1234_5678));
		send_word(make_cmd(KIND_ADD, 0, 1023, 32'h7FFF_FFFF));
		send_word(make_cmd(KIND_ADD, 1023, 1023, 32'h8000_0000));
		send_word(make_cmd(KIND_ADD, 0, 0, 32'h8000_0000));
		send_word(make_cmd(KIND_QUERY, 0, 0, 32'd0));
		send_word(make_cmd(KIND_QUERY, 1023, 1023, 32'd0));
		send_word(make_cmd(KIND_QUERY, 341, 682, 32'd0));
		// A load replaces a value that earlier range adds have changed.
		send_word(make_cmd(KIND_LOAD, 600, 0, 32'd5));
		send_word(make_cmd(KIND_QUERY, 599, 601, 32'd0));
		// Rejected words: low above high, unused kind.
		send_word(make_cmd(KIND_ADD, 10, 9, 32'd1));
		send_word(make_cmd(KIND_QUERY, 1023, 0, 32'd0));
		send_word(make_cmd(2'd3, 0, 1023, 32'hFFFF_FFFF));
		// Sums beyond 32 bits: four full-range adds of the largest value.
		for (int i = 0; i < 4; i++)
			send_word(make_cmd(KIND_ADD, 0, 1023, 32'h7FFF_FFFF));
		send_word(make_cmd(KIND_QUERY, 0, 1023, 32'd0));
		// Range beyond the array and load index beyond it, on a small array.
		write_size(11'd5);
		send_word(make_cmd(KIND_ADD, 2, 5, 32'd3));
		send_word(make_cmd(KIND_QUERY, 0, 5, 32'd0));
		send_word(make_cmd(KIND_LOAD, 5, 0, 32'd7));
		send_word(make_cmd(KIND_LOAD, 4, 0, 32'd7));
		send_word(make_cmd(KIND_QUERY, 0, 4, 32'd0));
	endtask

	// Random words on the current array size. Most words are valid; a few
	// run past the end of the array, have low above high, or use kind three.
	task automatic test_random(int count);
		cmd_t        c;
		int unsigned pick;
		int          lo;
		int          hi;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			lo = $urandom_range(0, array_size - 1);
			hi = $urandom_range(lo, array_size - 1);
			if (pick < 4) begin
				hi = $urandom_range(array_size - 1, MAX_ELEMS - 1);
				lo = $urandom_range(0, MAX_ELEMS - 1);
			end else if (pick < 7 && lo > 0) begin
				hi = $urandom_range(0, lo - 1);
			end
			c = make_cmd(pick < 9 && pick >= 7 ? 2'd3 :
				pick < 40 ? KIND_LOAD : pick < 70 ? KIND_ADD : KIND_QUERY,
				lo, hi, $urandom());
			if (c.kind == KIND_LOAD && $urandom_range(0, 3) == 0)
				c.operand_value = $urandom_range(0, 15) - 8;
			send_word(c);
		end
	endtask

	// Sizes sweep: the smallest, out-of-range writes and odd sizes.
	task automatic test_sizes();
		write_size(11'd1);
		test_random(50);
		write_size(11'd0);
		test_random(30);
		write_size(11'd2);
		test_random(60);
		write_size(11'd7);
		test_random(80);
		write_size(11'h7FF);
		test_random(200);
		write_size(11'($urandom_range(3, 1023)));
		test_random(120);
		write_size(11'd1024);
		test_random(150);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		word_count = 0;
		query_count = 0;
		reject_count = 0;
		burst_left = 0;
		array_size = MAX_ELEMS;
		clear_elems();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		write_size(11'd1024);
		test_random(430);
		test_sizes();
		drain();

		$display("Sent %0d words (%0d range sums, %0d rejected) over sizes 1, 2, 5, 7, a random one and 1024.",
			word_count, query_count, reject_count);
		$display("Mismatches seen: %0d.", mismatch_count);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/rarst_pkg.sv
hw/rtl/rarst_ram.sv
hw/rtl/range_add_range_sum_tree_core.sv
tb/tb.sv
